// ===== src/sel_pkg.sv =====
// types and constants shared by the stream event ledger files
`timescale 1ns / 1ps

package sel_pkg;

	localparam logic [2:0] CMD_CREATE  = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_DESTROY = 3'd3;
	localparam logic [2:0] CMD_OBSERVE = 3'd4;
	localparam logic [2:0] CMD_POLL    = 3'd5;
	localparam logic [2:0] CMD_CLEAR   = 3'd6;

	localparam logic [1:0] KIND_ENDED    = 2'd0;
	localparam logic [1:0] KIND_UNDERRUN = 2'd1;
	localparam logic [1:0] KIND_CREDIT   = 2'd2;

	localparam logic [15:0] RING_RESET = 16'd4096;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] handle;
		logic [15:0] accepted_frames;
		logic [31:0] end_count;
		logic [31:0] underrun_count;
		logic [15:0] ring_free;
	} item_t;

	typedef struct packed {
		logic        event_valid;
		logic [1:0]  event_kind;
		logic [15:0] event_handle;
		logic [15:0] event_free;
		logic [5:0]  queued_events;
		logic        overflow_seen;
	} result_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] handle;
		logic [15:0] free;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EVENT,
		ST_PURGE
	} state_t;

endpackage

// ===== src/sel_cell.sv =====
// one queue cell: holds an event entry, loads a new one or takes its neighbor's
`timescale 1ns / 1ps

module sel_cell (
	input  logic            clk,
	input  logic            shift,
	input  logic            load,
	input  sel_pkg::entry_t nbr,
	input  sel_pkg::entry_t din,
	output sel_pkg::entry_t q
);

	sel_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= din;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule

// ===== src/stream_event_ledger.sv =====
// top level: stream slot table and event queue built as a chain of cells
//
// channel   direction  handshake             payload
// item      in         start && !busy        item (sel_pkg::item_t)
// result    out        done, one cycle       result (sel_pkg::result_t)
// config    in         cfg_we                cfg_wdata (ring_frames)
//
// every item passes through the control sequencer: capture, then execute
// observe adds an event step for each changed counter (up to three)
// destroy adds a purge step per queued event, shifting the cell chain to compact it
// the result strobes in the cycle after the last step; the next item may start then
// reset clears the slots, the queue count and the overflow flag at once
`timescale 1ns / 1ps

module stream_event_ledger #(
	parameter int SLOT_COUNT = 8,
	parameter int FIFO_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sel_pkg::item_t   item,
	output logic             done,
	output sel_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata
);

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int RSH = 24;
	localparam logic [24:0] RECIP = 25'(((1 << RSH) + SLOT_COUNT - 1) / SLOT_COUNT);

	sel_pkg::state_t  state_q, state_d;
	sel_pkg::item_t   req_q;
	logic [15:0]      quot_q;
	logic [15:0]      ring_q;
	logic [15:0]      owner_q [SLOT_COUNT];
	logic [15:0]      credit_q [SLOT_COUNT];
	logic [31:0]      ends_q [SLOT_COUNT];
	logic [31:0]      unders_q [SLOT_COUNT];
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    scan_q, scan_d;
	logic [CW-1:0]    ld_idx;
	logic             ovf_q, ovf_d;
	logic [2:0]       pend_q, pend_d;
	logic             done_q;
	sel_pkg::result_t result_q;

	logic [40:0]      prod;
	logic [21:0]      qmul;
	logic [15:0]      rem;
	logic [SW-1:0]    sidx;
	logic             match;
	logic             full;
	logic             pop_en, push_en, push_req, clr, fin;
	sel_pkg::entry_t  push_data;
	sel_pkg::entry_t  cell_q [FIFO_DEPTH];
	sel_pkg::entry_t  nbr_w [FIFO_DEPTH];
	logic             ev_valid;
	logic [1:0]       ev_kind;
	logic [15:0]      ev_handle, ev_free;

	// slot select by reciprocal multiply, remainder taken in the next cycle
	assign prod = 41'(item.handle) * 41'(RECIP);
	assign qmul = 22'(quot_q) * 22'(SLOT_COUNT);
	assign rem = req_q.handle - qmul[15:0];
	assign sidx = SW'(rem);
	assign match = (req_q.handle != 16'd0) && (owner_q[sidx] == req_q.handle);
	assign full = (cnt_q == CW'(FIFO_DEPTH));
	assign ld_idx = pop_en ? (cnt_q - CW'(1)) : cnt_q;

	genvar gi;
	generate
		for (gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
			if (gi < FIFO_DEPTH - 1) begin : g_mid
				assign nbr_w[gi] = cell_q[gi + 1];
			end else begin : g_last
				assign nbr_w[gi] = '0;
			end
			sel_cell u_cell (
				.clk   (clk),
				.shift (pop_en),
				.load  (push_en && (ld_idx == CW'(gi))),
				.nbr   (nbr_w[gi]),
				.din   (push_data),
				.q     (cell_q[gi])
			);
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		scan_d    = scan_q;
		pend_d    = pend_q;
		pop_en    = 1'b0;
		push_req  = 1'b0;
		push_en   = 1'b0;
		push_data = '0;
		clr       = 1'b0;
		fin       = 1'b0;
		ev_valid  = 1'b0;
		ev_kind   = sel_pkg::KIND_ENDED;
		ev_handle = 16'd0;
		ev_free   = 16'd0;
		case (state_q)
			sel_pkg::ST_IDLE: begin
				if (start) begin
					state_d = sel_pkg::ST_EXEC;
				end
			end
			sel_pkg::ST_EXEC: begin
				case (req_q.command)
					sel_pkg::CMD_DESTROY: begin
						scan_d = cnt_q;
						if (cnt_q == '0) begin
							fin = 1'b1;
						end else begin
							state_d = sel_pkg::ST_PURGE;
						end
					end
					sel_pkg::CMD_OBSERVE: begin
						pend_d = match ? {(req_q.ring_free != credit_q[sidx]),
							(req_q.underrun_count != unders_q[sidx]),
							(req_q.end_count != ends_q[sidx])} : 3'b000;
						if (pend_d == 3'b000) begin
							fin = 1'b1;
						end else begin
							state_d = sel_pkg::ST_EVENT;
						end
					end
					sel_pkg::CMD_POLL: begin
						fin = 1'b1;
						if (cnt_q != '0) begin
							pop_en    = 1'b1;
							ev_valid  = 1'b1;
							ev_kind   = cell_q[0].kind;
							ev_handle = cell_q[0].handle;
							ev_free   = (cell_q[0].kind == sel_pkg::KIND_CREDIT) ?
								cell_q[0].free : 16'd0;
						end
					end
					sel_pkg::CMD_CLEAR: begin
						clr = 1'b1;
						fin = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			sel_pkg::ST_EVENT: begin
				push_req         = 1'b1;
				push_en          = !full;
				push_data.handle = req_q.handle;
				if (pend_q[0]) begin
					push_data.kind = sel_pkg::KIND_ENDED;
				end else if (pend_q[1]) begin
					push_data.kind = sel_pkg::KIND_UNDERRUN;
				end else begin
					push_data.kind = sel_pkg::KIND_CREDIT;
					push_data.free = req_q.ring_free;
				end
				pend_d = pend_q & (pend_q - 3'd1);
				if (pend_d == 3'b000) begin
					fin = 1'b1;
				end
			end
			sel_pkg::ST_PURGE: begin
				pop_en    = 1'b1;
				push_en   = (cell_q[0].handle != req_q.handle);
				push_data = cell_q[0];
				scan_d    = scan_q - CW'(1);
				if (scan_q == CW'(1)) begin
					fin = 1'b1;
				end
			end
			default: begin
				state_d = sel_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = sel_pkg::ST_IDLE;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (pop_en) begin
			cnt_d = cnt_d - CW'(1);
		end
		if (push_en) begin
			cnt_d = cnt_d + CW'(1);
		end
		if (clr) begin
			cnt_d = '0;
		end
		ovf_d = clr ? 1'b0 : (ovf_q | (push_req && full));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sel_pkg::ST_IDLE;
			cnt_q   <= '0;
			scan_q  <= '0;
			pend_q  <= 3'b000;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			scan_q  <= scan_d;
			pend_q  <= pend_d;
			ovf_q   <= ovf_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == sel_pkg::ST_IDLE)) begin
			req_q  <= item;
			quot_q <= prod[RSH+15:RSH];
		end
		if (fin) begin
			result_q.event_valid   <= ev_valid;
			result_q.event_kind    <= ev_kind;
			result_q.event_handle  <= ev_handle;
			result_q.event_free    <= ev_free;
			result_q.queued_events <= 6'(cnt_d);
			result_q.overflow_seen <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= sel_pkg::RING_RESET;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				owner_q[s]  <= 16'd0;
				credit_q[s] <= 16'd0;
				ends_q[s]   <= 32'd0;
				unders_q[s] <= 32'd0;
			end
		end else begin
			if (cfg_we) begin
				ring_q <= cfg_wdata;
			end
			if (state_q == sel_pkg::ST_EXEC) begin
				case (req_q.command)
					sel_pkg::CMD_CREATE: begin
						owner_q[sidx]  <= req_q.handle;
						credit_q[sidx] <= ring_q;
						ends_q[sidx]   <= 32'd0;
						unders_q[sidx] <= 32'd0;
					end
					sel_pkg::CMD_WRITE: begin
						if (match) begin
							credit_q[sidx] <= (req_q.accepted_frames > credit_q[sidx]) ?
								16'd0 : (credit_q[sidx] - req_q.accepted_frames);
						end
					end
					sel_pkg::CMD_STOP: begin
						if (match) begin
							credit_q[sidx] <= ring_q;
						end
					end
					sel_pkg::CMD_DESTROY: begin
						if (match) begin
							owner_q[sidx]  <= 16'd0;
							credit_q[sidx] <= 16'd0;
							ends_q[sidx]   <= 32'd0;
							unders_q[sidx] <= 32'd0;
						end
					end
					sel_pkg::CMD_OBSERVE: begin
						if (match) begin
							ends_q[sidx]   <= req_q.end_count;
							unders_q[sidx] <= req_q.underrun_count;
							credit_q[sidx] <= req_q.ring_free;
						end
					end
					sel_pkg::CMD_CLEAR: begin
						for (int s = 0; s < SLOT_COUNT; s++) begin
							owner_q[s]  <= 16'd0;
							credit_q[s] <= 16'd0;
							ends_q[s]   <= 32'd0;
							unders_q[s] <= 32'd0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign busy   = (state_q != sel_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/sel_checker.sv =====
// port-level checks on the stream event ledger, bound to the top level
`timescale 1ns / 1ps

module sel_checker #(
	parameter int FIFO_DEPTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input sel_pkg::result_t result
);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// one strobe per item
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// no popped event means empty event fields
	a_empty_event: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.event_valid |-> (result.event_kind == sel_pkg::KIND_ENDED)
			&& (result.event_handle == 16'd0) && (result.event_free == 16'd0))
		else $error("event fields set without a popped event");

	// free frames only travel with credit events, queue count within depth
	a_free_credit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.event_kind == sel_pkg::KIND_CREDIT) || (result.event_free == 16'd0))
			&& (32'(result.queued_events) <= FIFO_DEPTH))
		else $error("free frames on a non-credit event or queue count out of range");

endmodule

bind stream_event_ledger sel_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_sel_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== sim/event_ledger_checker.sv =====
// checker for the stream event ledger: tracks slots and event queue, compares every result
`timescale 1ns / 1ps

module event_ledger_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  sel_pkg::item_t   item,
	input  logic             done,
	input  sel_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_wdata,
	output int               fails,
	output int               outstanding
);

	localparam int SLOTS = 8;
	localparam int DEPTH = 32;
	localparam int PRINT_CAP = 100;

	logic [15:0]      ring_frames;
	logic [15:0]      owner [SLOTS];
	logic [15:0]      credit [SLOTS];
	logic [31:0]      seen_ends [SLOTS];
	logic [31:0]      seen_unders [SLOTS];
	sel_pkg::entry_t  events [DEPTH];
	logic [4:0]       head;
	logic [5:0]       count;
	logic             overflow;
	sel_pkg::result_t pending_results[$];
	sel_pkg::result_t want;
	sel_pkg::result_t next_result;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (fails < PRINT_CAP)
			$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, exp_val);
		fails = fails + 1;
	endtask

	task automatic clear_ledger();
		for (int i = 0; i < SLOTS; i++) begin
			owner[i] = '0;
			credit[i] = '0;
			seen_ends[i] = '0;
			seen_unders[i] = '0;
		end
		head = '0;
		count = '0;
		overflow = 1'b0;
	endtask

	task automatic push_entry(input logic [1:0] kind, input logic [15:0] h,
			input logic [15:0] free_val);
		logic [4:0] tail;
		if (count >= DEPTH) begin
			overflow = 1'b1;
		end else begin
			tail = head + count[4:0];
			events[tail].kind = kind;
			events[tail].handle = h;
			events[tail].free = free_val;
			count = count + 6'd1;
		end
	endtask

	task automatic purge_handle(input logic [15:0] h);
		sel_pkg::entry_t kept [DEPTH];
		int              n;
		logic [4:0]      at;
		n = 0;
		for (int i = 0; i < count; i++) begin
			at = head + i[4:0];
			if (events[at].handle != h) begin
				kept[n] = events[at];
				n++;
			end
		end
		for (int i = 0; i < n; i++)
			events[i] = kept[i];
		head = '0;
		count = n[5:0];
	endtask

	task automatic predict_item(input sel_pkg::item_t it, output sel_pkg::result_t r);
		logic [2:0]      s;
		logic            hit;
		sel_pkg::entry_t popped;
		s = it.handle[2:0];
		hit = (it.handle != 16'd0) && (owner[s] == it.handle);
		r = '0;
		case (it.command)
		sel_pkg::CMD_CREATE: begin
			owner[s] = it.handle;
			credit[s] = ring_frames;
			seen_ends[s] = '0;
			seen_unders[s] = '0;
		end
		sel_pkg::CMD_WRITE: begin
			if (hit)
				credit[s] = (it.accepted_frames > credit[s]) ? 16'd0 :
					credit[s] - it.accepted_frames;
		end
		sel_pkg::CMD_STOP: begin
			if (hit)
				credit[s] = ring_frames;
		end
		sel_pkg::CMD_DESTROY: begin
			purge_handle(it.handle);
			if (hit) begin
				owner[s] = '0;
				credit[s] = '0;
				seen_ends[s] = '0;
				seen_unders[s] = '0;
			end
		end
		sel_pkg::CMD_OBSERVE: begin
			if (hit) begin
				if (it.end_count != seen_ends[s]) begin
					seen_ends[s] = it.end_count;
					push_entry(sel_pkg::KIND_ENDED, it.handle, 16'd0);
				end
				if (it.underrun_count != seen_unders[s]) begin
					seen_unders[s] = it.underrun_count;
					push_entry(sel_pkg::KIND_UNDERRUN, it.handle, 16'd0);
				end
				if (it.ring_free != credit[s]) begin
					credit[s] = it.ring_free;
					push_entry(sel_pkg::KIND_CREDIT, it.handle, it.ring_free);
				end
			end
		end
		sel_pkg::CMD_POLL: begin
			if (count != 0) begin
				popped = events[head];
				r.event_valid = 1'b1;
				r.event_kind = popped.kind;
				r.event_handle = popped.handle;
				r.event_free = (popped.kind == sel_pkg::KIND_CREDIT) ? popped.free : 16'd0;
				head = head + 5'd1;
				count = count - 6'd1;
			end
		end
		sel_pkg::CMD_CLEAR: begin
			clear_ledger();
		end
		default: begin
		end
		endcase
		r.queued_events = count;
		r.overflow_seen = overflow;
	endtask

	task automatic compare_result(input sel_pkg::result_t got, input sel_pkg::result_t exp_r);
		if (got.event_valid !== exp_r.event_valid)
			report_mismatch("event_valid", 32'(got.event_valid), 32'(exp_r.event_valid));
		if (got.event_kind !== exp_r.event_kind)
			report_mismatch("event_kind", 32'(got.event_kind), 32'(exp_r.event_kind));
		if (got.event_handle !== exp_r.event_handle)
			report_mismatch("event_handle", 32'(got.event_handle), 32'(exp_r.event_handle));
		if (got.event_free !== exp_r.event_free)
			report_mismatch("event_free", 32'(got.event_free), 32'(exp_r.event_free));
		if (got.queued_events !== exp_r.queued_events)
			report_mismatch("queued_events", 32'(got.queued_events),
				32'(exp_r.queued_events));
		if (got.overflow_seen !== exp_r.overflow_seen)
			report_mismatch("overflow_seen", 32'(got.overflow_seen),
				32'(exp_r.overflow_seen));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_ledger();
			ring_frames = sel_pkg::RING_RESET;
			pending_results.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no item waiting", 32'(result.queued_events),
						32'd0);
				end else begin
					want = pending_results.pop_front();
					compare_result(result, want);
				end
			end
			if (cfg_we)
				ring_frames = cfg_wdata;
			if (start && !busy) begin
				predict_item(item, next_result);
				pending_results.push_back(next_result);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// testbench top for the stream event ledger: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int DRAIN_CYCLES = 40;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	sel_pkg::item_t   item;
	logic             done;
	sel_pkg::result_t result;
	logic             cfg_we;
	logic [15:0]      cfg_wdata;
	int               fails;
	int               outstanding;
	int               idle_cycles;

	logic [15:0] live_handle [8];
	logic [31:0] last_ends [8];
	logic [31:0] last_unders [8];
	logic [15:0] last_free [8];

	int          phase_idle [4] = '{0, 84, 0, 30};

	stream_event_ledger dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	event_ledger_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fails       (fails),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic sel_pkg::item_t make_item(input logic [2:0] cmd,
			input logic [15:0] h, input logic [15:0] acc, input logic [31:0] e,
			input logic [31:0] u, input logic [15:0] f);
		sel_pkg::item_t it;
		it.command = cmd;
		it.handle = h;
		it.accepted_frames = acc;
		it.end_count = e;
		it.underrun_count = u;
		it.ring_free = f;
		return it;
	endfunction

	// start stays high from one item to the next unless an idle gap is drawn
	task automatic send_item(input sel_pkg::item_t it, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= make_item(3'($urandom_range(7)), 16'($urandom), 16'($urandom),
				$urandom, $urandom, 16'($urandom));
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_ring(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly handles that own a slot, some strangers and slot collisions
	task automatic make_random_item(input int poll_pct, output sel_pkg::item_t it);
		int          r;
		logic [2:0]  s;
		logic [15:0] h;
		it = make_item(3'($urandom_range(7)), 16'($urandom), 16'($urandom), $urandom,
			$urandom, 16'($urandom));
		r = $urandom_range(99);
		if (r < poll_pct) begin
			it.command = sel_pkg::CMD_POLL;
		end else begin
			r = $urandom_range(99);
			if (r < 14)
				it.command = sel_pkg::CMD_CREATE;
			else if (r < 28)
				it.command = sel_pkg::CMD_WRITE;
			else if (r < 38)
				it.command = sel_pkg::CMD_STOP;
			else if (r < 48)
				it.command = sel_pkg::CMD_DESTROY;
			else if (r < 94)
				it.command = sel_pkg::CMD_OBSERVE;
			else if (r < 97)
				it.command = sel_pkg::CMD_CLEAR;
			else
				it.command = 3'd7;
		end
		s = 3'($urandom_range(7));
		r = $urandom_range(99);
		if (r < 65)
			h = live_handle[s];
		else if (r < 80)
			h = 16'($urandom);
		else if (r < 92)
			h = live_handle[s] ^ (16'h0008 << $urandom_range(12));
		else
			h = 16'h0000;
		if (it.command == sel_pkg::CMD_CREATE) begin
			h = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
			live_handle[h[2:0]] = h;
		end
		it.handle = h;
		s = h[2:0];
		r = $urandom_range(99);
		it.accepted_frames = (r < 50) ? 16'($urandom_range(255)) :
			(r < 80) ? 16'($urandom_range(4095)) : 16'($urandom);
		if (it.command == sel_pkg::CMD_OBSERVE) begin
			r = $urandom_range(99);
			if (r < 40)
				it.end_count = last_ends[s];
			else if (r < 80)
				it.end_count = last_ends[s] + 32'd1;
			last_ends[s] = it.end_count;
			r = $urandom_range(99);
			if (r < 40)
				it.underrun_count = last_unders[s];
			else if (r < 80)
				it.underrun_count = last_unders[s] + 32'd1;
			last_unders[s] = it.underrun_count;
			if ($urandom_range(99) < 45)
				it.ring_free = last_free[s];
			last_free[s] = it.ring_free;
		end
	endtask

	initial begin
		sel_pkg::item_t it;
		int             poll_pct;
		logic [15:0]    h;
		logic [31:0]    e;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		for (int i = 0; i < 8; i++) begin
			live_handle[i] = '0;
			last_ends[i] = '0;
			last_unders[i] = '0;
			last_free[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty poll, unused command, zero handle, saturation, overflow, purge
		send_item(make_item(sel_pkg::CMD_POLL, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hFFFF), 0);
		send_item(make_item(sel_pkg::CMD_CREATE, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_CREATE, 16'hFFFF, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_CREATE, 16'h0009, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_WRITE, 16'hFFFF, 16'd100, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_WRITE, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_WRITE, 16'h0011, 16'd5, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_STOP, 16'hFFFF, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_OBSERVE, 16'h0000, 16'h0000, 32'h1, 32'h1, 16'h1),
			0);
		for (int k = 0; k < 12; k++) begin
			h = k[0] ? 16'h0009 : 16'hFFFF;
			e = 32'(k) ^ {32{k[1]}};
			send_item(make_item(sel_pkg::CMD_OBSERVE, h, 16'h0000, e, ~e,
				16'(k) ^ {16{k[2]}}), 0);
		end
		send_item(make_item(sel_pkg::CMD_DESTROY, 16'h0009, 16'h0000, 32'h0, 32'h0, 16'h0),
			0);
		send_item(make_item(sel_pkg::CMD_POLL, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		send_item(make_item(sel_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 32'h0, 32'h0, 16'h0), 0);
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: write_ring(16'h0000);
			1: write_ring(16'hFFFF);
			2: write_ring(16'($urandom));
			default: write_ring(16'h0001);
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// alternate filling and draining the event queue
				poll_pct = ((n / 40) % 2 == 1) ? 50 : 12;
				make_random_item(poll_pct, it);
				send_item(it, phase_idle[p]);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
